// ===== rtl/core/fbfla_pkg.sv =====
package fbfla_pkg;

	localparam int MAX_BLOCKS   = 256;
	localparam int HEADER_BYTES = 8;
	localparam int IDX_W        = 8;
	localparam int CNT_W        = 9;
	localparam int POOL_W       = 21;
	localparam int PAY_W        = 17;
	localparam int STRIDE_W     = 18;
	localparam int OFF_W        = 20;
	localparam int PROD_W       = IDX_W + STRIDE_W;
	localparam int CMD_W        = 2;
	localparam int STATUS_W     = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_INIT  = 2'd0,
		CMD_ALLOC = 2'd1,
		CMD_FREE  = 2'd2,
		CMD_NOP   = 2'd3
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_RANGE     = 2'd2,
		ST_NOT_ALLOC = 2'd3
	} status_t;

	typedef struct packed {
		logic [POOL_W-1:0] pool_bytes;
		logic [PAY_W-1:0]  payload_bytes;
	} cfg_t;

	typedef struct packed {
		logic                start;
		logic [POOL_W-1:0]   dividend;
		logic [STRIDE_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [POOL_W-1:0] quotient;
	} div_rsp_t;

	typedef struct packed {
		status_t          status;
		logic [IDX_W-1:0] granted_index;
		logic [OFF_W-1:0] granted_offset;
		logic [CNT_W-1:0] blocks_free;
	} result_t;

endpackage

// ===== rtl/core/fixed_block_free_list_allocator.sv =====
// Fixed-size block pool allocator with a last-in first-out free list kept in an on-chip
// memory. An init beat carves pool_bytes into blocks of align4(8 + payload_bytes) bytes,
// at most 256 of them; allocations return the most recently freed index, after init the
// highest. Allocate and free issue one memory read in the accepting cycle; the next cycle
// writes the in-use map, and for a free the stack, and posts the result. A status-only
// result (empty pool, bad index, unused command) is posted in the accepting cycle itself;
// a stalled output holds any result in S_FIN. Init runs the one-bit-per-cycle block count
// divider, then refills the free list. Register writes take effect at the next init, and
// the output register lets a new beat enter while a result is still stalled.
module fixed_block_free_list_allocator (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [2:0]                          paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [fbfla_pkg::CMD_W-1:0]         command,
	input  logic [fbfla_pkg::IDX_W-1:0]         block_index,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [fbfla_pkg::STATUS_W-1:0]      status,
	output logic [fbfla_pkg::IDX_W-1:0]         granted_index,
	output logic [fbfla_pkg::OFF_W-1:0]         granted_offset,
	output logic [fbfla_pkg::CNT_W-1:0]         blocks_free
);
	import fbfla_pkg::*;

	localparam logic [POOL_W-1:0] POOL_RESET    = POOL_W'(4096);
	localparam logic [PAY_W-1:0]  PAYLOAD_RESET = PAY_W'(64);

	cfg_t     cfg_q;
	div_req_t div_req;
	div_rsp_t div_rsp;
	result_t  result;
	logic     cfg_write;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pool_bytes    <= POOL_RESET;
			cfg_q.payload_bytes <= PAYLOAD_RESET;
		end else if (cfg_write) begin
			if (paddr[2]) begin
				cfg_q.payload_bytes <= pwdata[PAY_W-1:0];
			end else begin
				cfg_q.pool_bytes <= pwdata[POOL_W-1:0];
			end
		end
	end

	assign prdata = paddr[2] ? {{(32 - PAY_W){1'b0}}, cfg_q.payload_bytes}
	                         : {{(32 - POOL_W){1'b0}}, cfg_q.pool_bytes};

	fbfla_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	fbfla_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.command     (command),
		.block_index (block_index),
		.div_req     (div_req),
		.div_rsp     (div_rsp),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.result      (result)
	);

	assign status         = result.status;
	assign granted_index  = result.granted_index;
	assign granted_offset = result.granted_offset;
	assign blocks_free    = result.blocks_free;

endmodule

// ===== rtl/core/fbfla_div.sv =====
module fbfla_div (
	input  logic                clk,
	input  logic                arst_n,
	input  fbfla_pkg::div_req_t req,
	output fbfla_pkg::div_rsp_t rsp
);
	import fbfla_pkg::*;

	localparam int DIV_CNT_W = $clog2(POOL_W + 1);

	logic [STRIDE_W-1:0]  rem_q;
	logic [POOL_W-1:0]    quo_q;
	logic [STRIDE_W-1:0]  den_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [STRIDE_W:0]    shifted;
	logic                 fits;

	assign shifted = {rem_q, quo_q[POOL_W-1]};
	assign fits    = shifted >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(POOL_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			den_q <= req.divisor;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= STRIDE_W'(shifted - {1'b0, den_q});
			end else begin
				rem_q <= shifted[STRIDE_W-1:0];
			end
			quo_q <= {quo_q[POOL_W-2:0], fits};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

// ===== rtl/core/fbfla_ctrl.sv =====
module fbfla_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  fbfla_pkg::cfg_t               cfg,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [fbfla_pkg::CMD_W-1:0]   command,
	input  logic [fbfla_pkg::IDX_W-1:0]   block_index,
	output fbfla_pkg::div_req_t           div_req,
	input  fbfla_pkg::div_rsp_t           div_rsp,
	output logic                          out_valid,
	input  logic                          out_stall,
	output fbfla_pkg::result_t            result
);
	import fbfla_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ALLOC,
		S_FREE,
		S_DIV,
		S_FILL,
		S_FIN
	} state_t;

	state_t              state_q;
	logic [CNT_W-1:0]    depth_q;
	logic [CNT_W-1:0]    count_q;
	logic [STRIDE_W-1:0] stride_q;
	logic [CNT_W-1:0]    fill_q;
	logic [IDX_W-1:0]    idx_q;
	result_t             res_q;
	result_t             out_q;
	logic                out_valid_q;

	logic [IDX_W-1:0] stack_mem [MAX_BLOCKS];
	logic             map_mem   [MAX_BLOCKS];
	logic [IDX_W-1:0] stack_rdata_q;
	logic             map_rdata_q;

	cmd_t                cmd;
	logic                accept;
	logic                slot_free;
	logic [STRIDE_W-1:0] stride_sum;
	logic [STRIDE_W-1:0] stride_new;
	logic [CNT_W-1:0]    count_new;
	logic                in_range;
	logic                stack_re;
	logic [IDX_W-1:0]    stack_raddr;
	logic                stack_we;
	logic [IDX_W-1:0]    stack_waddr;
	logic [IDX_W-1:0]    stack_wdata;
	logic                map_re;
	logic                map_we;
	logic [IDX_W-1:0]    map_waddr;
	logic                map_wdata;
	logic [PROD_W-1:0]   product;
	logic                fin_en;
	result_t             fin_res;

	assign cmd        = cmd_t'(command);
	assign accept     = in_valid && (state_q == S_IDLE);
	assign in_stall   = (state_q != S_IDLE);
	assign slot_free  = !out_valid_q || !out_stall;
	assign stride_sum = STRIDE_W'(cfg.payload_bytes) + STRIDE_W'(HEADER_BYTES + 3);
	assign stride_new = {stride_sum[STRIDE_W-1:2], 2'b00};
	assign count_new  = (div_rsp.quotient > POOL_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS)
	                                                             : div_rsp.quotient[CNT_W-1:0];
	assign in_range   = {1'b0, block_index} < count_q;
	assign product    = PROD_W'(stack_rdata_q) * PROD_W'(stride_q);

	assign div_req.start    = accept && (cmd == CMD_INIT) && (stride_new != '0);
	assign div_req.dividend = cfg.pool_bytes;
	assign div_req.divisor  = stride_new;

	assign stack_re    = accept && (cmd == CMD_ALLOC) && (depth_q != '0);
	assign stack_raddr = IDX_W'(depth_q - 1'b1);
	assign map_re      = accept && (cmd == CMD_FREE) && in_range;

	always_comb begin
		stack_we    = 1'b0;
		stack_waddr = fill_q[IDX_W-1:0];
		stack_wdata = fill_q[IDX_W-1:0];
		map_we      = 1'b0;
		map_waddr   = fill_q[IDX_W-1:0];
		map_wdata   = 1'b0;
		case (state_q)
			S_FILL: begin
				stack_we = (fill_q != count_q);
				map_we   = (fill_q != count_q);
			end
			S_ALLOC: begin
				map_we    = 1'b1;
				map_waddr = stack_rdata_q;
				map_wdata = 1'b1;
			end
			S_FREE: begin
				stack_we    = map_rdata_q;
				stack_waddr = depth_q[IDX_W-1:0];
				stack_wdata = idx_q;
				map_we      = map_rdata_q;
				map_waddr   = idx_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (stack_we) begin
			stack_mem[stack_waddr] <= stack_wdata;
		end
		if (stack_re) begin
			stack_rdata_q <= stack_mem[stack_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (map_we) begin
			map_mem[map_waddr] <= map_wdata;
		end
		if (map_re) begin
			map_rdata_q <= map_mem[block_index];
		end
	end

	always_comb begin
		fin_en                 = 1'b0;
		fin_res.status         = ST_OK;
		fin_res.granted_index  = '0;
		fin_res.granted_offset = '0;
		fin_res.blocks_free    = depth_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					case (cmd)
						CMD_ALLOC: begin
							fin_en         = (depth_q == '0);
							fin_res.status = ST_EMPTY;
						end
						CMD_FREE: begin
							fin_en         = !in_range;
							fin_res.status = ST_RANGE;
						end
						CMD_NOP: begin
							fin_en = 1'b1;
						end
						default: begin
						end
					endcase
				end
			end
			S_ALLOC: begin
				fin_en                 = 1'b1;
				fin_res.granted_index  = stack_rdata_q;
				fin_res.granted_offset = product[OFF_W-1:0];
				fin_res.blocks_free    = depth_q - 1'b1;
			end
			S_FREE: begin
				fin_en = 1'b1;
				if (map_rdata_q) begin
					fin_res.blocks_free = depth_q + 1'b1;
				end else begin
					fin_res.status = ST_NOT_ALLOC;
				end
			end
			S_FILL: begin
				fin_en              = (fill_q == count_q);
				fin_res.blocks_free = count_q;
			end
			S_FIN: begin
				fin_en  = 1'b1;
				fin_res = res_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			depth_q     <= '0;
			count_q     <= '0;
			stride_q    <= '0;
			fill_q      <= '0;
			idx_q       <= '0;
			res_q       <= '0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						idx_q  <= block_index;
						fill_q <= '0;
						case (cmd)
							CMD_INIT: begin
								stride_q <= stride_new;
								if (stride_new == '0) begin
									count_q <= '0;
									state_q <= S_FILL;
								end else begin
									state_q <= S_DIV;
								end
							end
							CMD_ALLOC: begin
								if (depth_q != '0) begin
									state_q <= S_ALLOC;
								end
							end
							CMD_FREE: begin
								if (in_range) begin
									state_q <= S_FREE;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_ALLOC: begin
					depth_q <= depth_q - 1'b1;
				end
				S_FREE: begin
					if (map_rdata_q) begin
						depth_q <= depth_q + 1'b1;
					end
				end
				S_DIV: begin
					if (div_rsp.done) begin
						count_q <= count_new;
						state_q <= S_FILL;
					end
				end
				S_FILL: begin
					if (fill_q == count_q) begin
						depth_q <= count_q;
					end else begin
						fill_q <= fill_q + 1'b1;
					end
				end
				default: begin
				end
			endcase
			if (fin_en && slot_free) begin
				out_valid_q <= 1'b1;
				out_q       <= fin_res;
				state_q     <= S_IDLE;
			end else if (fin_en) begin
				res_q   <= fin_res;
				state_q <= S_FIN;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign result    = out_q;

endmodule

// ===== dv/fixed_block_free_list_allocator_checker.sv =====
`timescale 1ns / 100ps

module fixed_block_free_list_allocator_checker
	import fbfla_pkg::*;
#(
	parameter logic [2:0] POOL_BYTES_ADDR    = 3'd0,
	parameter logic [2:0] PAYLOAD_BYTES_ADDR = 3'd4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic                pready,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	input  logic                in_valid,
	input  logic                in_stall,
	input  logic [CMD_W-1:0]    command,
	input  logic [IDX_W-1:0]    block_index,
	input  logic                out_valid,
	input  logic                out_stall,
	input  logic [STATUS_W-1:0] status,
	input  logic [IDX_W-1:0]    granted_index,
	input  logic [OFF_W-1:0]    granted_offset,
	input  logic [CNT_W-1:0]    blocks_free,
	output int                  fail_count,
	output int                  pending,
	output int                  results_seen
);

	logic [POOL_W-1:0] pool_bytes_reg;
	logic [PAY_W-1:0]  payload_bytes_reg;

	logic [IDX_W-1:0] free_list [MAX_BLOCKS];
	logic             in_use [MAX_BLOCKS];
	int unsigned      free_depth;
	int unsigned      pool_blocks;
	int unsigned      block_stride;

	result_t expected_results [$];

	function automatic void clear_pool_state();
		for (int i = 0; i < MAX_BLOCKS; i++) begin
			free_list[i] = '0;
			in_use[i] = 1'b0;
		end
		free_depth = 0;
		pool_blocks = 0;
		block_stride = 0;
	endfunction

	function automatic void carve_pool();
		int unsigned cap;
		int unsigned blocks;
		cap = (MAX_BLOCKS < 256) ? MAX_BLOCKS : 256;
		block_stride = (HEADER_BYTES + int'(payload_bytes_reg) + 3) & ~32'd3;
		blocks = (block_stride != 0) ? int'(pool_bytes_reg) / block_stride : 0;
		if (blocks > cap)
			blocks = cap;
		pool_blocks = blocks;
		for (int i = 0; i < MAX_BLOCKS; i++) begin
			in_use[i] = 1'b0;
			if (i < blocks)
				free_list[i] = IDX_W'(i);
		end
		free_depth = blocks;
	endfunction

	function automatic result_t predict_beat(cmd_t op, logic [IDX_W-1:0] idx);
		result_t     r;
		int unsigned top_idx;
		logic [63:0] product;
		r.status = ST_OK;
		r.granted_index = '0;
		r.granted_offset = '0;
		case (op)
			CMD_INIT: begin
				carve_pool();
			end
			CMD_ALLOC: begin
				if (free_depth == 0 || free_depth > MAX_BLOCKS) begin
					r.status = ST_EMPTY;
				end else begin
					top_idx = free_list[free_depth - 1];
					free_depth--;
					in_use[top_idx] = 1'b1;
					r.granted_index = IDX_W'(top_idx);
					product = 64'(top_idx) * 64'(block_stride);
					r.granted_offset = product[OFF_W-1:0];
				end
			end
			CMD_FREE: begin
				if (idx >= pool_blocks || idx >= MAX_BLOCKS) begin
					r.status = ST_RANGE;
				end else if (!in_use[idx]) begin
					r.status = ST_NOT_ALLOC;
				end else if (free_depth < MAX_BLOCKS) begin
					in_use[idx] = 1'b0;
					free_list[free_depth] = idx;
					free_depth++;
				end
			end
			default: begin
			end
		endcase
		r.blocks_free = CNT_W'(free_depth);
		return r;
	endfunction

	function automatic int field_matches(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			return 0;
		end
		return 1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		int      good;
		if (!arst_n) begin
			pool_bytes_reg <= POOL_W'(4096);
			payload_bytes_reg <= PAY_W'(64);
			clear_pool_state();
			expected_results.delete();
			fail_count <= 0;
			pending <= 0;
			results_seen <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr == POOL_BYTES_ADDR)
					pool_bytes_reg <= pwdata[POOL_W-1:0];
				else if (paddr == PAYLOAD_BYTES_ADDR)
					payload_bytes_reg <= pwdata[PAY_W-1:0];
			end
			if (in_valid && !in_stall)
				expected_results.push_back(predict_beat(cmd_t'(command), block_index));
			if (out_valid && !out_stall) begin
				results_seen <= results_seen + 1;
				if (expected_results.size() == 0) begin
					$error("result beat with no expectation pending");
					fail_count <= fail_count + 1;
				end else begin
					want = expected_results.pop_front();
					good = field_matches("status", want.status, status);
					good += field_matches("granted_index", want.granted_index, granted_index);
					good += field_matches("granted_offset", want.granted_offset, granted_offset);
					good += field_matches("blocks_free", want.blocks_free, blocks_free);
					fail_count <= fail_count + (4 - good);
				end
			end
			pending <= expected_results.size();
		end
	end

endmodule

// ===== dv/fixed_block_free_list_allocator_tb.sv =====
`timescale 1ns / 100ps

module fixed_block_free_list_allocator_tb;
	import fbfla_pkg::*;

	localparam logic [2:0] REG_POOL_BYTES    = 3'd0;
	localparam logic [2:0] REG_PAYLOAD_BYTES = 3'd4;
	localparam int         RANDOM_BEATS      = 1250;
	localparam int         HOLD_CYCLES       = 400;
	localparam int         SETTLE_CYCLES     = 40;
	localparam int         TIMEOUT_NS        = 2_000_000;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [2:0]          paddr;
	logic [31:0]         pwdata;
	logic [31:0]         prdata;
	logic                pready;
	logic                in_valid;
	logic                in_stall;
	logic [CMD_W-1:0]    command;
	logic [IDX_W-1:0]    block_index;
	logic                out_valid;
	logic                out_stall;
	logic [STATUS_W-1:0] status;
	logic [IDX_W-1:0]    granted_index;
	logic [OFF_W-1:0]    granted_offset;
	logic [CNT_W-1:0]    blocks_free;

	int fail_count;
	int pending;
	int results_seen;

	int unsigned send_idle_pct;
	int unsigned stall_pct;
	bit          hold_req;
	bit          hold_done;
	int          beats_sent;
	int          beats_by_cmd [4];
	int          settings_used;

	logic [IDX_W-1:0] granted_live [$];
	logic [IDX_W-1:0] last_freed;
	cmd_t             accepted_cmds [$];

	fixed_block_free_list_allocator i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.command        (command),
		.block_index    (block_index),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.granted_index  (granted_index),
		.granted_offset (granted_offset),
		.blocks_free    (blocks_free)
	);

	fixed_block_free_list_allocator_checker #(
		.POOL_BYTES_ADDR    (REG_POOL_BYTES),
		.PAYLOAD_BYTES_ADDR (REG_PAYLOAD_BYTES)
	) i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.pready         (pready),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.command        (command),
		.block_index    (block_index),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.granted_index  (granted_index),
		.granted_offset (granted_offset),
		.blocks_free    (blocks_free),
		.fail_count     (fail_count),
		.pending        (pending),
		.results_seen   (results_seen)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	initial begin
		#TIMEOUT_NS;
		$display("simulation failed");
		$finish;
	end

	// Result beats come back in command order, so the oldest accepted command tells
	// whether an ok result is a granted block worth freeing later.
	always @(posedge clk) begin
		cmd_t done_cmd;
		if (arst_n && in_valid && !in_stall)
			accepted_cmds.push_back(cmd_t'(command));
		if (arst_n && out_valid && !out_stall && accepted_cmds.size() != 0) begin
			done_cmd = accepted_cmds.pop_front();
			if (done_cmd == CMD_ALLOC && status == ST_OK)
				granted_live.push_back(granted_index);
		end
	end

	initial begin
		out_stall = 1'b0;
		hold_done = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				repeat (HOLD_CYCLES) begin
					out_stall <= 1'b1;
					@(posedge clk);
				end
				hold_done = 1'b1;
			end
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	task automatic send_beat(input cmd_t op, input logic [IDX_W-1:0] idx);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		command <= op;
		block_index <= idx;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		beats_sent++;
		beats_by_cmd[op]++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure_pool(input int unsigned pool, input int unsigned payload);
		wait_drained();
		write_reg(REG_POOL_BYTES, 32'(pool));
		write_reg(REG_PAYLOAD_BYTES, 32'(payload));
		settings_used++;
	endtask

	task automatic choose_setting();
		case ($urandom_range(9))
			0: configure_pool(1048576, $urandom_range(0, 24));
			1: configure_pool(2097151, ($urandom_range(1)) ? 131071 : 65536);
			2: configure_pool($urandom_range(0, 24), $urandom_range(0, 3));
			3: configure_pool($urandom_range(0, 2097151), $urandom_range(0, 131071));
			default: configure_pool($urandom_range(16, 400), $urandom_range(0, 60));
		endcase
	endtask

	task automatic run_random_sequence(input bit with_hold);
		int               ops;
		int unsigned      pick;
		int               k;
		logic [IDX_W-1:0] idx;
		choose_setting();
		granted_live.delete();
		send_beat(CMD_INIT, IDX_W'($urandom_range(255)));
		ops = $urandom_range(30, 90);
		for (int n = 0; n < ops; n++) begin
			if (with_hold && n == 5)
				hold_req = 1'b1;
			pick = $urandom_range(99);
			if (pick < 45 || (pick < 85 && granted_live.size() == 0)) begin
				send_beat(CMD_ALLOC, IDX_W'($urandom_range(255)));
			end else if (pick < 85) begin
				k = $urandom_range(granted_live.size() - 1);
				idx = granted_live[k];
				granted_live.delete(k);
				last_freed = idx;
				send_beat(CMD_FREE, idx);
			end else if (pick < 92) begin
				send_beat(CMD_FREE, IDX_W'($urandom_range(255)));
			end else if (pick < 96) begin
				send_beat(CMD_FREE, last_freed);
			end else if (pick < 99) begin
				send_beat(CMD_NOP, IDX_W'($urandom_range(255)));
			end else begin
				granted_live.delete();
				send_beat(CMD_INIT, IDX_W'($urandom_range(255)));
			end
		end
	endtask

	initial begin
		int directed_beats;
		int seq;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		command = CMD_NOP;
		block_index = '0;
		hold_req = 1'b0;
		last_freed = '0;
		beats_sent = 0;
		settings_used = 0;
		foreach (beats_by_cmd[i])
			beats_by_cmd[i] = 0;
		send_idle_pct = 15;
		stall_pct = 77;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_beat(CMD_ALLOC, 8'd0);
		send_beat(CMD_FREE, 8'd0);
		send_beat(CMD_NOP, 8'd255);
		send_beat(CMD_INIT, 8'd0);
		send_beat(CMD_ALLOC, 8'd0);
		send_beat(CMD_ALLOC, 8'd0);
		send_beat(CMD_FREE, 8'd55);
		send_beat(CMD_FREE, 8'd55);
		send_beat(CMD_FREE, 8'd56);
		send_beat(CMD_FREE, 8'd255);
		send_beat(CMD_FREE, 8'd0);
		send_beat(CMD_NOP, 8'd0);
		configure_pool(16, 0);
		send_beat(CMD_INIT, 8'd0);
		send_beat(CMD_ALLOC, 8'd0);
		send_beat(CMD_ALLOC, 8'd0);
		send_beat(CMD_ALLOC, 8'd0);
		send_beat(CMD_FREE, 8'd0);
		send_beat(CMD_FREE, 8'd1);
		send_beat(CMD_ALLOC, 8'd0);
		configure_pool(0, 65536);
		send_beat(CMD_INIT, 8'd0);
		send_beat(CMD_ALLOC, 8'd0);
		configure_pool(2097151, 131071);
		send_beat(CMD_INIT, 8'd0);
		send_beat(CMD_ALLOC, 8'd0);
		send_beat(CMD_ALLOC, 8'd0);
		send_beat(CMD_FREE, 8'd14);
		directed_beats = beats_sent;

		seq = 0;
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 15;
					stall_pct = 77;
				end
				1: begin
					send_idle_pct = 77;
					stall_pct = 15;
				end
				default: begin
					send_idle_pct = 0;
					stall_pct = 0;
				end
			endcase
			while (beats_sent < directed_beats + RANDOM_BEATS * (phase + 1) / 3) begin
				run_random_sequence(seq == 3);
				seq++;
			end
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Sent %0d beats: %0d init, %0d alloc, %0d free, %0d unused command.",
			beats_sent, beats_by_cmd[CMD_INIT], beats_by_cmd[CMD_ALLOC],
			beats_by_cmd[CMD_FREE], beats_by_cmd[CMD_NOP]);
		$display("Checked %0d result beats over %0d pool settings, long output hold-off %0s.",
			results_seen, settings_used, hold_done ? "done" : "missed");
		if (fail_count == 0 && pending == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
